// File: rtl/dowf_pkg.sv
// Package: shared constants, register codes and channel payload types for the outlier filter.
`timescale 1ns / 1ps
package dowf_pkg;

    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_WINDOW_RADIUS = 3;

    // Ring of line buffers: eight lines cover any radius up to three.
    localparam int RING_LINES = 8;
    localparam int LINE_BITS  = 3;

    localparam int PIX_BITS       = 8;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int LIMIT_BITS     = 8;
    localparam int CFG_BITS       = 13;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH     = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT    = HEIGHT_BITS'(480);
    localparam logic [LIMIT_BITS-1:0]  RST_DEVIATION_LIMIT = LIMIT_BITS'(10);

    localparam int MIN_FRAME = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH     = 2'd0,
        REG_FRAME_HEIGHT    = 2'd1,
        REG_DEVIATION_LIMIT = 2'd2
    } cfg_reg_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                command;
        logic [PIX_BITS-1:0] disparity_in;
    } pix_req_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] disparity_out;
        logic                was_removed;
        logic                end_of_frame;
    } pix_res_t;

endpackage

// File: rtl/disparity_outlier_window_filter.sv
// Top level: disparity speckle filter, line ring, column cell chain and sequencer.
//
//  channel | signals                         | direction
//  pixel   | pix_valid, pix_ready, pix_data  | request in
//  result  | res_valid, res_ready, res_data  | request out
//  config  | cfg_we, cfg_index, cfg_data     | write in
//
// A request that causes no result leaves the sequencer idle and ready. A result takes one
// column load of (2R+1) line ring reads, then capture and shift, then sum, total and
// decision; at the start of a row all (2R+1) columns reload, seven with radius 3.
// The single read port of the line ring serialises these reads.
// Reset clears counters and control; a stalled result holds in the output register.
`timescale 1ns / 1ps
module disparity_outlier_window_filter
    import dowf_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int WINDOW_RADIUS = DEF_WINDOW_RADIUS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  pix_req_t                  pix_data,
    output logic                      res_valid,
    input  logic                      res_ready,
    output pix_res_t                  res_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    localparam int N    = 2*WINDOW_RADIUS + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int AW   = LINE_BITS + CW;
    localparam int CS   = CW + 3;
    localparam int RS   = HEIGHT_BITS + 2;
    localparam int SW   = $clog2(N*255 + 1);
    localparam int CNTW = $clog2(N + 1);
    localparam int TSW  = $clog2(N*N*255 + 1);
    localparam int TCW  = $clog2(N*N + 1);
    localparam int DYW  = $clog2(N);
    localparam int PW   = LIMIT_BITS + 1 + TCW;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_CAP   = 7'b0000100,
        ST_SHIFT = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_TOTAL = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [WIDTH_BITS-1:0]  frame_width_reg;
    logic [HEIGHT_BITS-1:0] frame_height_reg;
    logic [LIMIT_BITS-1:0]  limit_reg;

    logic [CW-1:0]          in_col_reg, in_col_next;
    logic [HEIGHT_BITS-1:0] in_row_reg, in_row_next;
    logic [CW-1:0]          out_col_reg, out_col_next;
    logic [HEIGHT_BITS-1:0] out_row_reg, out_row_next;

    logic [DYW-1:0]         dy_reg, dy_next;
    logic [DYW-1:0]         cols_left_reg, cols_left_next;
    logic signed [CS-1:0]   load_col_reg, load_col_next;
    logic                   rd_valid_reg;

    logic [TSW-1:0]         total_sum_reg;
    logic [TCW-1:0]         total_cnt_reg;
    logic [TSW-1:0]         total_sum_c;
    logic [TCW-1:0]         total_cnt_c;

    logic                   res_valid_reg, res_valid_next;
    pix_res_t               res_data_reg, res_data_next;

    logic [WW-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;

    logic accept, is_drain, input_done, lag_ok, do_write, do_produce;
    logic geom_write, out_fire, removed;
    logic [PW-1:0] thr;

    logic signed [RS-1:0]   row_s;
    logic [HEIGHT_BITS-1:0] rd_row;
    logic [CW-1:0]          rd_col;
    logic [AW-1:0]          rd_addr;
    logic [PIX_BITS-1:0]    rd_data;

    logic [N-1:0][PIX_BITS-1:0] stage_reg;
    logic [N:0][N-1:0][PIX_BITS-1:0] col_bus;
    logic [N-1:0][SW-1:0]   part_sum;
    logic [N-1:0][CNTW-1:0] part_cnt;
    logic [PIX_BITS-1:0]    centre;
    logic                   shift_en;

    function automatic logic [CW-1:0] mirror_col(input logic signed [CS-1:0] c,
                                                 input logic [WW-1:0] w);
        logic signed [CS-1:0] ws;
        logic signed [CS-1:0] m;
        ws = $signed(CS'(w));
        if (c < 0)
            m = -c;
        else if (c >= ws)
            m = (ws <<< 1) - CS'(WINDOW_RADIUS) - c;
        else
            m = c;
        return m[CW-1:0];
    endfunction

    function automatic logic [HEIGHT_BITS-1:0] mirror_row(input logic signed [RS-1:0] r,
                                                          input logic [HEIGHT_BITS-1:0] h);
        logic signed [RS-1:0] hs;
        logic signed [RS-1:0] m;
        hs = $signed(RS'(h));
        if (r < 0)
            m = -r;
        else if (r >= hs)
            m = (hs <<< 1) - RS'(2) - r;
        else
            m = r;
        return m[HEIGHT_BITS-1:0];
    endfunction

    // effective geometry
    always_comb
    begin
        if (frame_width_reg < WIDTH_BITS'(MIN_FRAME))
            w_eff = WW'(MIN_FRAME);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(frame_width_reg);
        if (frame_height_reg < HEIGHT_BITS'(MIN_FRAME))
            h_eff = HEIGHT_BITS'(MIN_FRAME);
        else
            h_eff = frame_height_reg;
    end

    assign pix_ready  = (state_reg == ST_IDLE);
    assign accept     = pix_valid && pix_ready;
    assign is_drain   = (pix_data.command == CMD_DRAIN);
    assign input_done = (in_row_reg >= h_eff);
    assign lag_ok     = (in_row_reg > HEIGHT_BITS'(WINDOW_RADIUS)) ||
                        ((in_row_reg == HEIGHT_BITS'(WINDOW_RADIUS)) &&
                         (in_col_reg >= CW'(WINDOW_RADIUS)));
    assign do_write   = accept && !is_drain && !input_done;
    assign do_produce = accept && (is_drain ? input_done : (!input_done && lag_ok));
    assign geom_write = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                   (cfg_index == REG_FRAME_HEIGHT));

    // line ring
    assign row_s   = $signed(RS'(out_row_reg)) - RS'(WINDOW_RADIUS) + $signed(RS'(dy_reg));
    assign rd_row  = mirror_row(row_s, h_eff);
    assign rd_col  = mirror_col(load_col_reg, w_eff);
    assign rd_addr = {rd_row[LINE_BITS-1:0], rd_col};

    dowf_line_store #(
        .COL_BITS (CW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr ({in_row_reg[LINE_BITS-1:0], in_col_reg}),
        .wr_data (pix_data.disparity_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            for (int j = 0; j < N-1; j++)
            begin
                stage_reg[j] <= stage_reg[j+1];
            end
            stage_reg[N-1] <= rd_data;
        end
    end

    // column cell chain, leftmost column in cell 0
    assign shift_en   = (state_reg == ST_SHIFT);
    assign col_bus[N] = stage_reg;
    assign centre     = col_bus[WINDOW_RADIUS][WINDOW_RADIUS];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        dowf_cell #(
            .N (N)
        ) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .col_in   (col_bus[k+1]),
            .centre   (centre),
            .col_out  (col_bus[k]),
            .part_sum (part_sum[k]),
            .part_cnt (part_cnt[k])
        );
    end

    always_comb
    begin
        total_sum_c = '0;
        total_cnt_c = '0;
        for (int k = 0; k < N; k++)
        begin
            total_sum_c = total_sum_c + TSW'(part_sum[k]);
            total_cnt_c = total_cnt_c + TCW'(part_cnt[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TOTAL)
        begin
            total_sum_reg <= total_sum_c;
            total_cnt_reg <= total_cnt_c;
        end
    end

    // mean >= limit + 1  <=>  sum >= (limit + 1) * count
    assign thr      = PW'(({1'b0, limit_reg} + 9'd1)) * PW'(total_cnt_reg);
    assign removed  = (centre != '0) && (32'(total_sum_reg) >= 32'(thr));
    assign out_fire = (state_reg == ST_OUT) && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next     = state_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        dy_next        = dy_reg;
        cols_left_next = cols_left_reg;
        load_col_next  = load_col_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_data_next  = res_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_write)
                begin
                    if ((WW'(in_col_reg) + WW'(1)) >= w_eff)
                    begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + HEIGHT_BITS'(1);
                    end
                    else
                    begin
                        in_col_next = in_col_reg + CW'(1);
                    end
                end
                if (do_produce)
                begin
                    dy_next = '0;
                    if (out_col_reg == '0)
                    begin
                        load_col_next  = -CS'(WINDOW_RADIUS);
                        cols_left_next = DYW'(N-1);
                    end
                    else
                    begin
                        load_col_next  = $signed(CS'(out_col_reg)) + CS'(WINDOW_RADIUS);
                        cols_left_next = '0;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (dy_reg == DYW'(N-1))
                begin
                    dy_next    = '0;
                    state_next = ST_CAP;
                end
                else
                begin
                    dy_next = dy_reg + DYW'(1);
                end
            end
            ST_CAP:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (cols_left_reg != '0)
                begin
                    cols_left_next = cols_left_reg - DYW'(1);
                    load_col_next  = load_col_reg + CS'(1);
                    state_next     = ST_LOAD;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    res_valid_next              = 1'b1;
                    res_data_next.disparity_out = removed ? '0 : centre;
                    res_data_next.was_removed   = removed;
                    res_data_next.end_of_frame  = 1'b0;
                    if ((WW'(out_col_reg) + WW'(1)) >= w_eff)
                    begin
                        out_col_next = '0;
                        if ((out_row_reg + HEIGHT_BITS'(1)) >= h_eff)
                        begin
                            res_data_next.end_of_frame = 1'b1;
                            out_row_next = '0;
                            in_col_next  = '0;
                            in_row_next  = '0;
                        end
                        else
                        begin
                            out_row_next = out_row_reg + HEIGHT_BITS'(1);
                        end
                    end
                    else
                    begin
                        out_col_next = out_col_reg + CW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (geom_write)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            limit_reg        <= RST_DEVIATION_LIMIT;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            dy_reg           <= '0;
            cols_left_reg    <= '0;
            load_col_reg     <= '0;
            rd_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            dy_reg        <= dy_next;
            cols_left_reg <= cols_left_next;
            load_col_reg  <= load_col_next;
            rd_valid_reg  <= (state_reg == ST_LOAD);
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:     frame_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                    REG_FRAME_HEIGHT:    frame_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                    REG_DEVIATION_LIMIT: limit_reg        <= cfg_data[LIMIT_BITS-1:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_out_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(out_col_reg) < w_eff))
        else $error("output column beyond frame width");

    a_in_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_row_reg <= h_eff))
        else $error("input row beyond frame height");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside decision state");

    a_shift_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> $past(state_reg == ST_CAP))
        else $error("window shift without completed column load");

endmodule

// File: rtl/dowf_line_store.sv
// Line buffer ring: one write port, one registered read port.
`timescale 1ns / 1ps
module dowf_line_store
    import dowf_pkg::*;
#(
    parameter int COL_BITS = 10
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [LINE_BITS+COL_BITS-1:0] wr_addr,
    input  logic [PIX_BITS-1:0]           wr_data,
    input  logic [LINE_BITS+COL_BITS-1:0] rd_addr,
    output logic [PIX_BITS-1:0]           rd_data
);

    localparam int DEPTH = RING_LINES << COL_BITS;

    logic [PIX_BITS-1:0] mem [DEPTH];
    logic [PIX_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/dowf_cell.sv
// Window column cell: holds one column, passes it left on shift, registers its deviation partials.
`timescale 1ns / 1ps
module dowf_cell
    import dowf_pkg::*;
#(
    parameter int N = 7
)
(
    input  logic                          clk,
    input  logic                          shift_en,
    input  logic [N-1:0][PIX_BITS-1:0]    col_in,
    input  logic [PIX_BITS-1:0]           centre,
    output logic [N-1:0][PIX_BITS-1:0]    col_out,
    output logic [$clog2(N*255+1)-1:0]    part_sum,
    output logic [$clog2(N+1)-1:0]        part_cnt
);

    localparam int SW   = $clog2(N*255+1);
    localparam int CNTW = $clog2(N+1);

    logic [N-1:0][PIX_BITS-1:0] col_reg;
    logic [SW-1:0]              sum_c;
    logic [CNTW-1:0]            cnt_c;
    logic [PIX_BITS-1:0]        diff;
    logic [SW-1:0]              part_sum_reg;
    logic [CNTW-1:0]            part_cnt_reg;

    always_comb
    begin
        sum_c = '0;
        cnt_c = '0;
        diff  = '0;
        for (int j = 0; j < N; j++)
        begin
            diff = (col_reg[j] > centre) ? col_reg[j] - centre : centre - col_reg[j];
            if (col_reg[j] != '0)
            begin
                sum_c = sum_c + SW'(diff);
                cnt_c = cnt_c + CNTW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            col_reg <= col_in;
        end
        part_sum_reg <= sum_c;
        part_cnt_reg <= cnt_c;
    end

    assign col_out  = col_reg;
    assign part_sum = part_sum_reg;
    assign part_cnt = part_cnt_reg;

endmodule
